/* hw/rtl/far_pkg.sv */
// Shared constants, operation codes and unit status type for the fraction reducer.
`default_nettype none

package far_pkg;

  localparam int OPERAND_WIDTH = 16;

  localparam int PROD_W      = 2 * OPERAND_WIDTH;
  localparam int NMAG_W      = PROD_W + 1;
  localparam int IN_TDATA_W  = ((4 * OPERAND_WIDTH + 7) / 8) * 8;
  localparam int OUT_NUM_W   = 33;
  localparam int OUT_DEN_W   = 32;
  localparam int OUT_TDATA_W = ((OUT_NUM_W + OUT_DEN_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_NUM_W - OUT_DEN_W;
  localparam int NUMX_W      = (NMAG_W > OUT_NUM_W) ? NMAG_W : OUT_NUM_W;
  localparam int DENX_W      = (NMAG_W > OUT_DEN_W) ? NMAG_W : OUT_DEN_W;
  localparam int DIV_CNT_W   = $clog2(NMAG_W + 1);

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Magnitude of a two's complement operand; the most negative value maps to 2^(W-1).
  function automatic logic [OPERAND_WIDTH-1:0] op_mag(input logic [OPERAND_WIDTH-1:0] v);
    logic [OPERAND_WIDTH-1:0] neg_v;
    neg_v = ~v + 1'b1;
    return v[OPERAND_WIDTH-1] ? neg_v : v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/far_mul.sv */
// Shared magnitude multiplier with a registered product.
`default_nettype none

module far_mul
  import far_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic [OPERAND_WIDTH-1:0] mul_a,
  input  wire logic [OPERAND_WIDTH-1:0] mul_b,
  output logic      [PROD_W-1:0]        prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

`default_nettype wire

/* hw/rtl/far_div.sv */
// Restoring divider, one quotient bit per cycle, shared for both reductions.
`default_nettype none

module far_div
  import far_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NMAG_W-1:0] dividend,
  input  wire logic [NMAG_W-1:0] divisor,
  output unit_stat_t             stat,
  output logic      [NMAG_W-1:0] quot_r
);

  logic [NMAG_W-1:0]    rem_r;
  logic [NMAG_W-1:0]    dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [NMAG_W:0]   trial;
  logic [NMAG_W:0]   diff;
  logic              fits;

  assign trial = {rem_r, quot_r[NMAG_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(NMAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= dividend;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[NMAG_W-1:0] : trial[NMAG_W-1:0];
      quot_r <= {quot_r[NMAG_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

/* hw/rtl/far_gcd.sv */
// Binary GCD engine: one shift or subtract-and-shift per cycle, halving copies of n and d alongside.
`default_nettype none

module far_gcd
  import far_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NMAG_W-1:0] n_mag,
  input  wire logic [NMAG_W-1:0] d_mag,
  output unit_stat_t             stat,
  output logic      [NMAG_W-1:0] odd_gcd_r,
  output logic      [NMAG_W-1:0] n_sh_r,
  output logic      [NMAG_W-1:0] d_sh_r
);

  logic [NMAG_W-1:0] b_r;
  logic              busy_r;
  logic              done_r;
  logic              a_gt_b;
  logic [NMAG_W-1:0] a_m_b;
  logic [NMAG_W-1:0] b_m_a;

  assign a_gt_b = (odd_gcd_r > b_r);
  assign a_m_b  = odd_gcd_r - b_r;
  assign b_m_a  = b_r - odd_gcd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (odd_gcd_r == b_r)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // a zero numerator reduces by the denominator itself
      odd_gcd_r <= (n_mag == '0) ? d_mag : n_mag;
      b_r       <= d_mag;
      n_sh_r    <= n_mag;
      d_sh_r    <= d_mag;
    end else if (busy_r && (odd_gcd_r != b_r)) begin
      if (!odd_gcd_r[0] && !b_r[0]) begin
        // common factor of two: strip it from the running copies too
        odd_gcd_r <= odd_gcd_r >> 1;
        b_r       <= b_r >> 1;
        n_sh_r    <= n_sh_r >> 1;
        d_sh_r    <= d_sh_r >> 1;
      end else if (!odd_gcd_r[0]) begin
        odd_gcd_r <= odd_gcd_r >> 1;
      end else if (!b_r[0]) begin
        b_r <= b_r >> 1;
      end else if (a_gt_b) begin
        odd_gcd_r <= a_m_b >> 1;
      end else begin
        b_r <= b_m_a >> 1;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

/* hw/rtl/fraction_arith_reduce_top.sv */
// Sequence: multiply steps on the shared multiplier, combine, binary GCD, then two restoring
//   divides (numerator, then denominator) and a final output step.
// A zero denominator skips the GCD and both divides.
// Items are not overlapped: a new one is taken only in idle; the GCD steps and the divider set how long each takes.
// A finished result sits in the output register, so the next item is taken while it waits.
// Reset: synchronous, active low; clears the sequencer and valid flags, no memories to clear.
`default_nettype none

module fraction_arith_reduce_top
  import far_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // num_a, den_a, num_b, den_b
  input  wire logic [OP_W-1:0]        in_tuser,   // req_type
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // num_out, den_out, zero pad
  output logic                        out_tuser   // status
);

  localparam int W = OPERAND_WIDTH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_COMB = 3'd2;
  localparam logic [2:0] ST_GCD  = 3'd3;
  localparam logic [2:0] ST_DIVN = 3'd4;
  localparam logic [2:0] ST_DIVD = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [1:0] mcnt_r;

  logic [OP_W-1:0] op_r;
  logic [W-1:0]    na_m_r, da_m_r, nb_m_r, db_m_r;
  logic            na_s_r, da_s_r, nb_s_r, db_s_r;
  logic [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic [NMAG_W-1:0] nm_r, dm_r;
  logic              n_neg_r, d_neg_r, err_r;

  logic            in_fire;
  logic            out_free;
  logic [W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0] prod;

  // combine stage
  logic              s0, s1, ds;
  logic [NMAG_W-1:0] p0x, p1x, sum_mag;
  logic              sum_neg;

  unit_stat_t        gcd_st, div_st;
  logic              gcd_start, div_start;
  logic [NMAG_W-1:0] gcd_g, gcd_n, gcd_d, div_q, div_dividend;

  logic [NUMX_W-1:0] nmx, numv;
  logic [DENX_W-1:0] dmx;
  logic              res_neg;
  logic              out_valid_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // operand pairs: add/sub na*db, nb*da, da*db; mul na*nb, -, da*db; div na*db, -, da*nb
  always_comb begin
    case (mcnt_r)
      2'd0: begin
        mul_a = na_m_r;
        mul_b = (op_r == OP_MUL) ? nb_m_r : db_m_r;
      end
      2'd1: begin
        mul_a = nb_m_r;
        mul_b = da_m_r;
      end
      default: begin
        mul_a = da_m_r;
        mul_b = (op_r == OP_DIV) ? nb_m_r : db_m_r;
      end
    endcase
  end

  far_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod)
  );

  always_comb begin
    s0 = ((op_r == OP_MUL) ? (na_s_r ^ nb_s_r) : (na_s_r ^ db_s_r)) && (p0_r != '0);
    s1 = (((op_r == OP_SUB) ? !nb_s_r : nb_s_r) ^ da_s_r) && (p1_r != '0);
    ds = ((op_r == OP_DIV) ? (da_s_r ^ nb_s_r) : (da_s_r ^ db_s_r)) && (p2_r != '0);
    p0x = NMAG_W'(p0_r);
    p1x = NMAG_W'(p1_r);
    if ((op_r == OP_MUL) || (op_r == OP_DIV)) begin
      sum_mag = p0x;
      sum_neg = s0;
    end else if (s0 == s1) begin
      sum_mag = p0x + p1x;
      sum_neg = s0;
    end else if (p0x >= p1x) begin
      sum_mag = p0x - p1x;
      sum_neg = s0;
    end else begin
      sum_mag = p1x - p0x;
      sum_neg = s1;
    end
  end

  assign gcd_start = (state_r == ST_COMB) && (p2_r != '0);

  far_gcd u_gcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (gcd_start),
    .n_mag     (sum_mag),
    .d_mag     (NMAG_W'(p2_r)),
    .stat      (gcd_st),
    .odd_gcd_r (gcd_g),
    .n_sh_r    (gcd_n),
    .d_sh_r    (gcd_d)
  );

  assign div_start    = ((state_r == ST_GCD) && gcd_st.done) ||
                        ((state_r == ST_DIVN) && div_st.done);
  assign div_dividend = (state_r == ST_GCD) ? gcd_n : gcd_d;

  far_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gcd_g),
    .stat     (div_st),
    .quot_r   (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_MUL;
      ST_MUL:  if (mcnt_r == 2'd3) state_nxt = ST_COMB;
      ST_COMB: state_nxt = (p2_r == '0) ? ST_FIN : ST_GCD;
      ST_GCD:  if (gcd_st.done) state_nxt = ST_DIVN;
      ST_DIVN: if (div_st.done) state_nxt = ST_DIVD;
      ST_DIVD: if (div_st.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mcnt_r  <= (state_r == ST_MUL) ? mcnt_r + 1'b1 : 2'd0;
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_tuser;
      na_m_r <= op_mag(in_tdata[W-1:0]);
      da_m_r <= op_mag(in_tdata[2*W-1:W]);
      nb_m_r <= op_mag(in_tdata[3*W-1:2*W]);
      db_m_r <= op_mag(in_tdata[4*W-1:3*W]);
      na_s_r <= in_tdata[W-1];
      da_s_r <= in_tdata[2*W-1];
      nb_s_r <= in_tdata[3*W-1];
      db_s_r <= in_tdata[4*W-1];
    end
    if (state_r == ST_MUL) begin
      if (mcnt_r == 2'd1) p0_r <= prod;
      if (mcnt_r == 2'd2) p1_r <= prod;
      if (mcnt_r == 2'd3) p2_r <= prod;
    end
    if (state_r == ST_COMB) begin
      n_neg_r <= sum_neg && (sum_mag != '0);
      d_neg_r <= ds;
      err_r   <= (p2_r == '0);
    end
    if ((state_r == ST_DIVN) && div_st.done) nm_r <= div_q;
    if ((state_r == ST_DIVD) && div_st.done) dm_r <= div_q;
  end

  assign nmx     = NUMX_W'(nm_r);
  assign dmx     = DENX_W'(dm_r);
  assign res_neg = (n_neg_r != d_neg_r) && (nm_r != '0);
  assign numv    = res_neg ? (~nmx + 1'b1) : nmx;

  always_ff @(posedge clk) begin
    if ((state_r == ST_FIN) && out_free) begin
      if (err_r) begin
        out_tdata <= '0;
        out_tuser <= 1'b1;
      end else begin
        out_tdata <= {{OUT_PAD_W{1'b0}}, dmx[OUT_DEN_W-1:0], numv[OUT_NUM_W-1:0]};
        out_tuser <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error result carries nonzero data");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("block ready right after taking an item");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    gcd_st.done |-> gcd_g != '0)
    else $error("gcd finished with zero divisor");

  a_div_not_during_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GCD |-> !div_st.busy)
    else $error("divider active during gcd search");

endmodule

`default_nettype wire
